/* hw/rtl/grid_maze_shortest_path_assert.svh */
// assertion macros shared by the checker files
`ifndef GRID_MAZE_SHORTEST_PATH_ASSERT_SVH
`define GRID_MAZE_SHORTEST_PATH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GMSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmsp assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define GMSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmsp assertion failed");

`endif

/* hw/rtl/gmsp_pkg.sv */
package gmsp_pkg;

  // maze size limits
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int CELL_CAP = MAX_ROWS * MAX_COLS;

  // field and register widths
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int LEN_W     = 11;

  // derived widths
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
  localparam int CNT_W  = $clog2(CELL_CAP + 1);
  localparam int DIM_W  = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
  localparam int VAL_W  = CNT_W + 1;

  // largest result the output can show
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam int LEN_CAP = (CELL_CAP > ((1 << LEN_W) - 1)) ? ((1 << LEN_W) - 1) : CELL_CAP;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  // step directions: up, right, down, left
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // bit positions in a map entry
  localparam int MAP_REACH = 0;
  localparam int MAP_WALL  = 1;

  // one cell position, kept both as row/column and as linear address
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ADDR_W-1:0] idx;
  } cell_t;

  // neighbor of a cell and whether it lies inside the maze
  typedef struct packed {
    logic  ok;
    cell_t loc;
  } nbr_t;

  // register value as used: zero reads as one, large values clamp to the cap
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v, input int cap);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > cap) begin
      res = DIM_W'(cap);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage

/* hw/rtl/gmsp_nbr.sv */
module gmsp_nbr (
  input  gmsp_pkg::cell_t             cur_cell,
  input  logic [1:0]                  dir,
  input  logic [gmsp_pkg::DIM_W-1:0]  rows,
  input  logic [gmsp_pkg::DIM_W-1:0]  cols,
  output gmsp_pkg::nbr_t              nbr
);
  import gmsp_pkg::*;

  localparam int EXT_W = DIM_W + 1;

  logic [CNT_W-1:0] idx_w;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] sum;

  // neighbor position and bounds check for one direction
  always_comb begin
    idx_w   = CNT_W'(cur_cell.idx);
    step    = CNT_W'(cols);
    sum     = idx_w;
    nbr.ok  = 1'b0;
    nbr.loc = cur_cell;
    unique case (dir)
      DIR_UP: begin
        nbr.ok      = (cur_cell.row != '0);
        nbr.loc.row = cur_cell.row - 1'b1;
        sum         = idx_w - step;
      end
      DIR_RIGHT: begin
        nbr.ok      = (EXT_W'(cur_cell.col) + EXT_W'(1)) < EXT_W'(cols);
        nbr.loc.col = cur_cell.col + 1'b1;
        sum         = idx_w + CNT_W'(1);
      end
      DIR_DOWN: begin
        nbr.ok      = (EXT_W'(cur_cell.row) + EXT_W'(1)) < EXT_W'(rows);
        nbr.loc.row = cur_cell.row + 1'b1;
        sum         = idx_w + step;
      end
      DIR_LEFT: begin
        nbr.ok      = (cur_cell.col != '0);
        nbr.loc.col = cur_cell.col - 1'b1;
        sum         = idx_w - CNT_W'(1);
      end
      default: begin
        nbr.ok = 1'b0;
      end
    endcase
    nbr.loc.idx = sum[ADDR_W-1:0];
  end

endmodule

/* hw/rtl/grid_maze_shortest_path.sv */
// grid_maze_shortest_path: four-neighbor wavefront search over a stored maze
// loading: one cell item per cycle; the last cell starts the search
// search: each reached cell takes a queue read plus up to four map reads; after that,
// every queued cell is read back to clear its mark, and then the result is given
// reset: synchronous, active low; a pass over the whole map then clears the marks
// before the first item is taken (configuration writes are taken throughout)
module grid_maze_shortest_path (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cell_blocked,
  input  logic                              in_last_cell,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gmsp_pkg::LEN_W-1:0]        out_path_length,
  input  logic                              cfg_we,
  input  logic [gmsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gmsp_pkg::CFG_W-1:0]        cfg_data
);
  import gmsp_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
  localparam logic [ST_W-1:0] ST_LOAD   = 3'd1;
  localparam logic [ST_W-1:0] ST_START  = 3'd2;
  localparam logic [ST_W-1:0] ST_DEQ    = 3'd3;
  localparam logic [ST_W-1:0] ST_EXPAND = 3'd4;
  localparam logic [ST_W-1:0] ST_SWEEP  = 3'd5;
  localparam int PROD_W = 2 * DIM_W;

  // control state
  logic [ST_W-1:0]  state_r, state_nxt;
  logic [CFG_W-1:0] row_count_r, row_count_nxt;
  logic [CFG_W-1:0] col_count_r, col_count_nxt;
  logic [CNT_W-1:0] load_idx_r, load_idx_nxt;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic             swp_v_r, swp_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // search payload
  logic              start_wall_r, start_wall_nxt;
  logic [DIM_W-1:0]  rows_r, rows_nxt;
  logic [DIM_W-1:0]  cols_r, cols_nxt;
  logic [CNT_W-1:0]  limit_r, limit_nxt;
  logic [ADDR_W-1:0] goal_r, goal_nxt;
  logic [CNT_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  level_end_r, level_end_nxt;
  logic [CNT_W-1:0]  dist_r, dist_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic              chk_byp_r, chk_byp_nxt;
  cell_t             chk_cell_r, chk_cell_nxt;
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  res_dist_r, res_dist_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  // map memory: wall bit and reached bit per cell
  logic [1:0]        map_mem [CELL_CAP];
  logic [1:0]        map_rd_r;
  logic              map_re;
  logic [ADDR_W-1:0] map_raddr;
  logic              map_we_wall;
  logic              map_we_reach;
  logic [ADDR_W-1:0] map_waddr;
  logic              map_wwall;
  logic              map_wreach;

  // wavefront queue memory
  cell_t             q_mem [CELL_CAP];
  cell_t             q_rd_r;
  logic              q_re;
  logic [ADDR_W-1:0] q_raddr;
  logic              q_we;
  logic [ADDR_W-1:0] q_waddr;
  cell_t             q_wdata;

  // misc combinational
  nbr_t              nbr;
  logic              in_acc;
  logic              out_free;
  logic              chk_fire;
  logic              chk_take;
  logic              chk_goal;
  logic [DIM_W-1:0]  eff_rows;
  logic [DIM_W-1:0]  eff_cols;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  lim_c;
  logic [CNT_W-1:0]  goal_c;
  logic [VAL_W-1:0]  sum_v;
  logic [VAL_W-1:0]  lim_v;
  logic [VAL_W-1:0]  val;
  logic [LEN_W-1:0]  len_c;

  gmsp_nbr u_nbr (
    .cur_cell (q_rd_r),
    .dir      (dir_r),
    .rows     (rows_r),
    .cols     (cols_r),
    .nbr      (nbr)
  );

  assign in_ready        = (state_r == ST_LOAD);
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_path_length = out_len_r;
  assign out_free        = !out_valid_r || out_ready;

  // maze size as used by the search
  always_comb begin
    eff_rows = eff_dim(row_count_r, MAX_ROWS);
    eff_cols = eff_dim(col_count_r, MAX_COLS);
    prod     = PROD_W'(eff_rows) * PROD_W'(eff_cols);
    lim_c    = CNT_W'(prod);
    goal_c   = lim_c - CNT_W'(1);
  end

  // result: start value plus steps, capped at cell count and output range
  always_comb begin
    sum_v = VAL_W'(start_wall_r) + VAL_W'(res_dist_r);
    lim_v = VAL_W'(limit_r);
    val   = (found_r && (sum_v < lim_v)) ? sum_v : lim_v;
    len_c = (32'(val) > 32'(LEN_MAX)) ? LEN_MAX : LEN_W'(val);
  end

  // neighbor check stage: map data from the read issued last cycle
  always_comb begin
    chk_fire = chk_v_r && ((state_r == ST_EXPAND) || (state_r == ST_DEQ));
    chk_take = chk_fire && !map_rd_r[MAP_WALL] && !map_rd_r[MAP_REACH] && !chk_byp_r;
    chk_goal = chk_take && (chk_cell_r.idx == goal_r);
  end

  // main sequencer
  always_comb begin
    state_nxt      = state_r;
    row_count_nxt  = row_count_r;
    col_count_nxt  = col_count_r;
    load_idx_nxt   = load_idx_r;
    head_nxt       = head_r;
    chk_v_nxt      = 1'b0;
    swp_v_nxt      = 1'b0;
    out_valid_nxt  = out_valid_r;
    start_wall_nxt = start_wall_r;
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    limit_nxt      = limit_r;
    goal_nxt       = goal_r;
    tail_nxt       = tail_r;
    level_end_nxt  = level_end_r;
    dist_nxt       = dist_r;
    dir_nxt        = dir_r;
    chk_byp_nxt    = chk_byp_r;
    chk_cell_nxt   = chk_cell_r;
    found_nxt      = found_r;
    res_dist_nxt   = res_dist_r;
    out_len_nxt    = out_len_r;
    map_re         = 1'b0;
    map_raddr      = '0;
    map_we_wall    = 1'b0;
    map_we_reach   = 1'b0;
    map_waddr      = '0;
    map_wwall      = 1'b0;
    map_wreach     = 1'b0;
    q_re           = 1'b0;
    q_raddr        = '0;
    q_we           = 1'b0;
    q_waddr        = '0;
    q_wdata        = '0;

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count_nxt = cfg_data;
        REG_COLUMN_COUNT: col_count_nxt = cfg_data;
        default: ;
      endcase
    end

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // new open neighbor: mark reached and enqueue
    if (chk_take) begin
      map_we_reach = 1'b1;
      map_waddr    = chk_cell_r.idx;
      map_wreach   = 1'b1;
      q_we         = 1'b1;
      q_waddr      = tail_r[ADDR_W-1:0];
      q_wdata      = chk_cell_r;
      tail_nxt     = tail_r + CNT_W'(1);
    end
    if (chk_goal) begin
      found_nxt    = 1'b1;
      res_dist_nxt = dist_r + CNT_W'(1);
    end

    unique case (state_r)
      ST_CLEAR: begin
        map_we_reach = 1'b1;
        map_waddr    = head_r[ADDR_W-1:0];
        map_wreach   = 1'b0;
        head_nxt     = head_r + CNT_W'(1);
        if (head_r == CNT_W'(CELL_CAP - 1)) begin
          head_nxt  = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (in_acc) begin
          if (load_idx_r < CNT_W'(CELL_CAP)) begin
            map_we_wall  = 1'b1;
            map_waddr    = load_idx_r[ADDR_W-1:0];
            map_wwall    = in_cell_blocked;
            load_idx_nxt = load_idx_r + CNT_W'(1);
          end
          if (load_idx_r == '0) begin
            start_wall_nxt = in_cell_blocked;
          end
          if (in_last_cell) begin
            load_idx_nxt = '0;
            state_nxt    = ST_START;
          end
        end
      end
      ST_START: begin
        rows_nxt      = eff_rows;
        cols_nxt      = eff_cols;
        limit_nxt     = lim_c;
        goal_nxt      = goal_c[ADDR_W-1:0];
        map_we_reach  = 1'b1;
        map_waddr     = '0;
        map_wreach    = 1'b1;
        q_we          = 1'b1;
        q_waddr       = '0;
        q_wdata       = '0;
        head_nxt      = '0;
        tail_nxt      = CNT_W'(1);
        level_end_nxt = CNT_W'(1);
        dist_nxt      = '0;
        found_nxt     = 1'b0;
        res_dist_nxt  = '0;
        state_nxt     = ST_DEQ;
      end
      ST_DEQ: begin
        if (limit_r == CNT_W'(1)) begin
          // start cell is the goal
          found_nxt    = 1'b1;
          res_dist_nxt = '0;
          head_nxt     = '0;
          state_nxt    = ST_SWEEP;
        end else if (chk_goal || (head_r == tail_nxt)) begin
          head_nxt  = '0;
          state_nxt = ST_SWEEP;
        end else begin
          q_re     = 1'b1;
          q_raddr  = head_r[ADDR_W-1:0];
          head_nxt = head_r + CNT_W'(1);
          if (head_r == level_end_r) begin
            dist_nxt      = dist_r + CNT_W'(1);
            level_end_nxt = tail_nxt;
          end
          dir_nxt   = DIR_UP;
          state_nxt = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (chk_goal) begin
          head_nxt  = '0;
          state_nxt = ST_SWEEP;
        end else begin
          if (nbr.ok) begin
            map_re       = 1'b1;
            map_raddr    = nbr.loc.idx;
            chk_v_nxt    = 1'b1;
            chk_cell_nxt = nbr.loc;
            // a mark written this cycle is not yet in the read data
            chk_byp_nxt  = map_we_reach && map_wreach && (map_waddr == nbr.loc.idx);
          end
          dir_nxt = dir_r + 2'd1;
          if (dir_r == DIR_LEFT) begin
            state_nxt = ST_DEQ;
          end
        end
      end
      ST_SWEEP: begin
        // clear the marks of every queued cell
        if (swp_v_r) begin
          map_we_reach = 1'b1;
          map_waddr    = q_rd_r.idx;
          map_wreach   = 1'b0;
        end
        if (head_r < tail_r) begin
          q_re      = 1'b1;
          q_raddr   = head_r[ADDR_W-1:0];
          head_nxt  = head_r + CNT_W'(1);
          swp_v_nxt = 1'b1;
        end else if (!swp_v_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = len_c;
          head_nxt      = '0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        head_nxt  = '0;
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_count_r <= CFG_W'(32);
      col_count_r <= CFG_W'(32);
      load_idx_r  <= '0;
      head_r      <= '0;
      chk_v_r     <= 1'b0;
      swp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      load_idx_r  <= load_idx_nxt;
      head_r      <= head_nxt;
      chk_v_r     <= chk_v_nxt;
      swp_v_r     <= swp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    start_wall_r <= start_wall_nxt;
    rows_r       <= rows_nxt;
    cols_r       <= cols_nxt;
    limit_r      <= limit_nxt;
    goal_r       <= goal_nxt;
    tail_r       <= tail_nxt;
    level_end_r  <= level_end_nxt;
    dist_r       <= dist_nxt;
    dir_r        <= dir_nxt;
    chk_byp_r    <= chk_byp_nxt;
    chk_cell_r   <= chk_cell_nxt;
    found_r      <= found_nxt;
    res_dist_r   <= res_dist_nxt;
    out_len_r    <= out_len_nxt;
  end

  // map memory with per-bit write enables
  always_ff @(posedge clk) begin
    if (map_we_wall) begin
      map_mem[map_waddr][MAP_WALL] <= map_wwall;
    end
    if (map_we_reach) begin
      map_mem[map_waddr][MAP_REACH] <= map_wreach;
    end
    if (map_re) begin
      map_rd_r <= map_mem[map_raddr];
    end
  end

  // queue memory, read forwards a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_r <= (q_we && (q_waddr == q_raddr)) ? q_wdata : q_mem[q_raddr];
    end
  end

endmodule

/* hw/rtl/gmsp_checker.sv */
`include "grid_maze_shortest_path_assert.svh"

module gmsp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_cell_blocked,
  input logic                              in_last_cell,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gmsp_pkg::LEN_W-1:0]        out_path_length,
  input logic                              cfg_we,
  input logic [gmsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [gmsp_pkg::CFG_W-1:0]        cfg_data
);
  import gmsp_pkg::*;

  // a stalled result keeps its value
  `GMSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_path_length))

  // result never exceeds the cell count of the largest maze
  `GMSP_ASSERT_IMP(a_len_range, out_valid, 32'(out_path_length) <= LEN_CAP)

  // the last cell of a maze stops intake while the search runs
  `GMSP_ASSERT_NXT(a_last_stops, in_valid && in_ready && in_last_cell, !in_ready)

  // a new result only comes out of a search, never out of the loading phase
  `GMSP_ASSERT_IMP(a_out_from_search, $rose(out_valid), !$past(in_ready))

endmodule

bind grid_maze_shortest_path gmsp_checker u_gmsp_checker (.*);

/* bench/grid_maze_shortest_path_test.sv */
module grid_maze_shortest_path_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gmsp_pkg::*;

  localparam int ITEM_TARGET    = 1850;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PRINT_LIMIT    = 40;

  // neighbor offsets: up, right, down, left
  localparam int ROW_STEP [4] = '{-1, 0, 1, 0};
  localparam int COL_STEP [4] = '{0, 1, 0, -1};

  // one directed cell item, with the maze size in force and an optional known result
  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic             wall;
    logic             last;
    logic             typed;
    logic [LEN_W-1:0] want;
  } maze_cell_t;

  localparam int DIRECTED_N = 20;
  localparam maze_cell_t DIRECTED_CELLS [DIRECTED_N] = '{
    // single cell maze, open then wall
    '{6'd1, 6'd1, 1'b0, 1'b1, 1'b1, 11'd0},
    '{6'd1, 6'd1, 1'b1, 1'b1, 1'b1, 11'd1},
    // zero sizes behave as one
    '{6'd0, 6'd0, 1'b1, 1'b1, 1'b1, 11'd1},
    '{6'd0, 6'd0, 1'b0, 1'b1, 1'b1, 11'd0},
    // open 2x2
    '{6'd2, 6'd2, 1'b0, 1'b0, 1'b0, 11'd0},
    '{6'd2, 6'd2, 1'b0, 1'b0, 1'b0, 11'd0},
    '{6'd2, 6'd2, 1'b0, 1'b0, 1'b0, 11'd0},
    '{6'd2, 6'd2, 1'b0, 1'b1, 1'b1, 11'd2},
    // 2x2 cut off by a diagonal wall
    '{6'd2, 6'd2, 1'b0, 1'b0, 1'b0, 11'd0},
    '{6'd2, 6'd2, 1'b1, 1'b0, 1'b0, 11'd0},
    '{6'd2, 6'd2, 1'b1, 1'b0, 1'b0, 11'd0},
    '{6'd2, 6'd2, 1'b0, 1'b1, 1'b1, 11'd4},
    // short maze reuses older cells, walled start is still entered
    '{6'd2, 6'd2, 1'b1, 1'b0, 1'b0, 11'd0},
    '{6'd2, 6'd2, 1'b0, 1'b1, 1'b0, 11'd0},
    // walled start plus steps hits the rows*cols cap
    '{6'd1, 6'd3, 1'b1, 1'b0, 1'b0, 11'd0},
    '{6'd1, 6'd3, 1'b0, 1'b0, 1'b0, 11'd0},
    '{6'd1, 6'd3, 1'b0, 1'b1, 1'b0, 11'd0},
    // walled goal cannot be reached
    '{6'd3, 6'd1, 1'b0, 1'b0, 1'b0, 11'd0},
    '{6'd3, 6'd1, 1'b0, 1'b0, 1'b0, 11'd0},
    '{6'd3, 6'd1, 1'b1, 1'b1, 1'b1, 11'd3}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cell_blocked = 1'b0;
  logic in_last_cell = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LEN_W-1:0] out_path_length;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROW_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state: stored maze, load position, registers as written
  bit maze_wall [CELL_CAP];
  int unsigned load_pos = 0;
  int unsigned written_span = 0;
  logic [CFG_W-1:0] row_reg = 6'd32;
  logic [CFG_W-1:0] col_reg = 6'd32;

  logic [LEN_W-1:0] pending_lengths [$];
  logic [LEN_W-1:0] oldest_length;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned cells_sent = 0;
  int unsigned calm_left = 0;
  int unsigned ready_hold = 0;

  always #1 clk = ~clk;

  grid_maze_shortest_path i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_blocked (in_cell_blocked),
    .in_last_cell    (in_last_cell),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_path_length (out_path_length),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // size actually used: zero means one, large values clamp to the cap
  function automatic int dim_in_use(input logic [CFG_W-1:0] v, input int cap);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > cap) begin
      return cap;
    end
    return int'(v);
  endfunction

  // level-by-level flood from the top-left cell toward the bottom-right cell
  function automatic logic [LEN_W-1:0] shortest_path_length();
    int rows;
    int cols;
    int area;
    int goal;
    int steps;
    int r;
    int c;
    int nr;
    int nc;
    int idx;
    int length;
    bit found;
    bit seen [CELL_CAP];
    int wave [$];
    int next_wave [$];
    rows = dim_in_use(row_reg, MAX_ROWS);
    cols = dim_in_use(col_reg, MAX_COLS);
    area = rows * cols;
    goal = area - 1;
    steps = 0;
    found = 1'b0;
    seen[0] = 1'b1;
    wave.push_back(0);
    while (wave.size() > 0) begin
      foreach (wave[i]) begin
        if (wave[i] == goal) found = 1'b1;
      end
      if (found) break;
      next_wave.delete();
      foreach (wave[i]) begin
        r = wave[i] / cols;
        c = wave[i] % cols;
        for (int k = 0; k < 4; k++) begin
          nr = r + ROW_STEP[k];
          nc = c + COL_STEP[k];
          if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
          idx = nr * cols + nc;
          if (seen[idx] || maze_wall[idx]) continue;
          seen[idx] = 1'b1;
          next_wave.push_back(idx);
        end
      end
      wave = next_wave;
      steps++;
    end
    length = area;
    if (found && (int'(maze_wall[0]) + steps) < length) begin
      length = int'(maze_wall[0]) + steps;
    end
    if (length > 2047) length = 2047;
    return LEN_W'(length);
  endfunction

  // present one cell item, hold it until taken, then update the predictor
  task automatic send_cell(input logic wall, input logic last, input logic typed,
                           input logic [LEN_W-1:0] want);
    in_valid <= 1'b1;
    in_cell_blocked <= wall;
    in_last_cell <= last;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
    if (load_pos < CELL_CAP) begin
      maze_wall[load_pos] = wall;
      load_pos++;
      if (load_pos > written_span) written_span = load_pos;
    end
    if (last) begin
      pending_lengths.push_back(typed ? want : shortest_path_length());
      load_pos = 0;
    end
  endtask

  // source gaps: mostly none or short, a few long, with calm stretches
  task automatic source_gap();
    int unsigned pick;
    int unsigned n;
    n = 0;
    pick = $urandom_range(0, 39);
    if (calm_left > 0) begin
      calm_left--;
    end else if (pick == 0) begin
      calm_left = $urandom_range(20, 80);
    end else if (pick < 25) begin
      n = 0;
    end else if (pick < 35) begin
      n = $urandom_range(1, 3);
    end else if (pick < 39) begin
      n = $urandom_range(4, 10);
    end else begin
      n = $urandom_range(15, 40);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait until every result is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lengths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= REG_COLUMN_COUNT;
    cfg_data <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    row_reg = rows;
    col_reg = cols;
  endtask

  // one random maze: mostly complete, some short or overlong
  task automatic send_random_maze();
    int area;
    int count;
    int density;
    int unsigned pick;
    logic wall;
    area = dim_in_use(row_reg, MAX_ROWS) * dim_in_use(col_reg, MAX_COLS);
    count = area;
    pick = $urandom_range(0, 9);
    if (pick == 8 && area > 1 && area <= int'(written_span)) begin
      count = $urandom_range(1, area - 1);
    end else if (pick == 9) begin
      count = area + $urandom_range(1, 6);
    end
    case ($urandom_range(0, 4))
      0: density = 0;
      1: density = 10;
      2: density = 25;
      3: density = 40;
      default: density = 60;
    endcase
    for (int i = 0; i < count; i++) begin
      if (i == 0) begin
        wall = ($urandom_range(0, 99) < 20);
      end else begin
        wall = ($urandom_range(0, 99) < density);
      end
      send_cell(wall, i == count - 1, 1'b0, '0);
      source_gap();
    end
  endtask

  // result side: ready pattern with short stalls, rare long ones, long runs of ready
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          out_ready <= 1'b1;
          ready_hold <= $urandom_range(0, 20);
        end
        6, 7, 8: begin
          out_ready <= 1'b0;
          ready_hold <= $urandom_range(0, 3);
        end
        default: begin
          out_ready <= 1'b0;
          ready_hold <= $urandom_range(10, 40);
        end
      endcase
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (pending_lengths.size() == 0) begin
          flag_mismatch($sformatf("path_length %0d with no maze pending", out_path_length));
        end else begin
          oldest_length = pending_lengths.pop_front();
          if (out_path_length !== oldest_length) begin
            flag_mismatch($sformatf("path_length got %0d want %0d",
                                    out_path_length, oldest_length));
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[grid_maze_shortest_path] ERROR");
        $finish;
      end
    end
  end

  initial begin
    maze_cell_t row;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed mazes
    for (int i = 0; i < DIRECTED_N; i++) begin
      row = DIRECTED_CELLS[i];
      if (row.rows != row_reg || row.cols != col_reg) begin
        set_dims(row.rows, row.cols);
      end
      send_cell(row.wall, row.last, row.typed, row.want);
      source_gap();
    end

    // full-size maze from oversized registers, overlong so the cells past the map size are dropped
    set_dims(6'd63, 6'd33);
    for (int i = 0; i < CELL_CAP + 3; i++) begin
      send_cell($urandom_range(0, 99) < 20, i == CELL_CAP + 2, 1'b0, '0);
      source_gap();
    end

    // random mazes, mostly small, a few long and thin
    while (cells_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          rows = CFG_W'($urandom_range(32, 63));
          cols = CFG_W'($urandom_range(0, 2));
          if ($urandom_range(0, 1) == 1) begin
            set_dims(cols, rows);
          end else begin
            set_dims(rows, cols);
          end
        end else begin
          set_dims(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)));
        end
      end
      send_random_maze();
    end

    // drain and finish
    in_valid <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[grid_maze_shortest_path] OK");
    end else begin
      $display("[grid_maze_shortest_path] ERROR");
    end
    $finish;
  end

endmodule
